// ----- hdl/cfd_pkg.sv -----
package cfd_pkg;

  // marker bytes that open a frame
  localparam logic [7:0] MARK_FIRST  = 8'h21;
  localparam logic [7:0] MARK_SECOND = 8'h4B;

  // body byte positions after the marker
  localparam int unsigned POS_W = 4;
  localparam logic [POS_W-1:0] POS_SEQ_B0 = 4'd0;
  localparam logic [POS_W-1:0] POS_SEQ_B1 = 4'd1;
  localparam logic [POS_W-1:0] POS_SEQ_B2 = 4'd2;
  localparam logic [POS_W-1:0] POS_SEQ_B3 = 4'd3;
  localparam logic [POS_W-1:0] POS_X      = 4'd4;
  localparam logic [POS_W-1:0] POS_Y      = 4'd5;
  localparam logic [POS_W-1:0] POS_BTN_B0 = 4'd6;
  localparam logic [POS_W-1:0] POS_BTN_B1 = 4'd7;
  localparam logic [POS_W-1:0] POS_LAST   = 4'd8;

  localparam int unsigned SEQ_W = 32;
  localparam int unsigned STK_W = 8;
  localparam int unsigned BTN_W = 24;

  // finished frame handed from the parser to the hold stage
  typedef struct packed {
    logic             done;
    logic [SEQ_W-1:0] seq;
    logic [STK_W-1:0] x;
    logic [STK_W-1:0] y;
    logic [BTN_W-1:0] buttons;
  } frame_t;

endpackage

// ----- hdl/cfd_parse.sv -----
module cfd_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_vld,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_datagram,
  output cfd_pkg::frame_t      frame
);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_SEEN = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  phase_t                         phase_r, phase_nxt;
  logic [cfd_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic [cfd_pkg::SEQ_W-1:0]      seq_r, seq_nxt;
  logic [cfd_pkg::STK_W-1:0]      x_r, x_nxt;
  logic [cfd_pkg::STK_W-1:0]      y_r, y_nxt;
  logic [15:0]                    btn_r, btn_nxt;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    seq_nxt   = seq_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    btn_nxt   = btn_r;
    case (phase_r)
      PH_BODY: begin
        case (pos_r)
          cfd_pkg::POS_SEQ_B0: seq_nxt[7:0]   = data_byte;
          cfd_pkg::POS_SEQ_B1: seq_nxt[15:8]  = data_byte;
          cfd_pkg::POS_SEQ_B2: seq_nxt[23:16] = data_byte;
          cfd_pkg::POS_SEQ_B3: seq_nxt[31:24] = data_byte;
          cfd_pkg::POS_X:      x_nxt          = data_byte;
          cfd_pkg::POS_Y:      y_nxt          = data_byte;
          cfd_pkg::POS_BTN_B0: btn_nxt[7:0]   = data_byte;
          cfd_pkg::POS_BTN_B1: btn_nxt[15:8]  = data_byte;
          default: ;
        endcase
        if (pos_r >= cfd_pkg::POS_LAST) begin
          phase_nxt = PH_HUNT;
          pos_nxt   = '0;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      PH_SEEN: begin
        if (data_byte == cfd_pkg::MARK_SECOND) begin
          phase_nxt = PH_BODY;
          pos_nxt   = '0;
          seq_nxt   = '0;
          x_nxt     = '0;
          y_nxt     = '0;
          btn_nxt   = '0;
        end else if (data_byte == cfd_pkg::MARK_FIRST) begin
          phase_nxt = PH_SEEN;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      default: begin
        phase_nxt = (data_byte == cfd_pkg::MARK_FIRST) ? PH_SEEN : PH_HUNT;
      end
    endcase
    if (end_of_datagram) begin
      phase_nxt = PH_HUNT;
      pos_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      pos_r   <= '0;
      seq_r   <= '0;
      x_r     <= '0;
      y_r     <= '0;
      btn_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      seq_r   <= seq_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      btn_r   <= btn_nxt;
    end
  end

  // last body byte completes the frame in the same pass
  always_comb begin
    frame.done    = byte_vld && (phase_r == PH_BODY) && (pos_r >= cfd_pkg::POS_LAST);
    frame.seq     = seq_r;
    frame.x       = x_r;
    frame.y       = y_r;
    frame.buttons = {data_byte, btn_r};
  end

endmodule

// ----- hdl/cfd_hold.sv -----
module cfd_hold (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  cfd_pkg::frame_t             frame,
  output logic                        busy,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_frame_accepted,
  output logic [cfd_pkg::SEQ_W-1:0]   out_frame_sequence,
  output logic [cfd_pkg::STK_W-1:0]   out_stick_x,
  output logic [cfd_pkg::STK_W-1:0]   out_stick_y,
  output logic [cfd_pkg::BTN_W-1:0]   out_button_bits
);

  logic [cfd_pkg::SEQ_W-1:0] last_r;
  logic [cfd_pkg::STK_W-1:0] hx_r, hx_nxt;
  logic [cfd_pkg::STK_W-1:0] hy_r, hy_nxt;
  logic [cfd_pkg::BTN_W-1:0] hb_r, hb_nxt;
  logic                      vld_r;
  logic                      acc_r;
  logic [cfd_pkg::SEQ_W-1:0] seq_r;
  logic                      fresh;
  logic                      load;

  // zero doubles as nothing accepted yet
  assign fresh = (last_r == '0) || (frame.seq >= last_r);
  assign load  = step && frame.done;
  assign busy  = vld_r && out_stall;

  always_comb begin
    hx_nxt = fresh ? frame.x       : hx_r;
    hy_nxt = fresh ? frame.y       : hy_r;
    hb_nxt = fresh ? frame.buttons : hb_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      last_r <= '0;
      hx_r   <= '0;
      hy_r   <= '0;
      hb_r   <= '0;
    end else begin
      if (load) begin
        vld_r <= 1'b1;
        hx_r  <= hx_nxt;
        hy_r  <= hy_nxt;
        hb_r  <= hb_nxt;
        if (fresh) begin
          last_r <= frame.seq;
        end
      end else if (!out_stall) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      acc_r <= fresh;
      seq_r <= frame.seq;
    end
  end

  assign out_valid          = vld_r;
  assign out_frame_accepted = acc_r;
  assign out_frame_sequence = seq_r;
  assign out_stick_x        = hx_r;
  assign out_stick_y        = hy_r;
  assign out_button_bits    = hb_r;

endmodule

// ----- hdl/controller_frame_deframer.sv -----
// Controller frame deframer: takes datagram bytes one beat at a time, hunts for the
// marker '!' 'K', then gathers a 9-byte body (32-bit little-endian sequence number,
// stick x, stick y, 24-bit little-endian buttons). A frame whose sequence number is
// below the last accepted one is reported as stale and leaves the held values alone;
// the first frame after reset is always taken. A beat with end_of_datagram set drops
// any partial marker or frame, though a frame completing on that very beat is still
// reported. Each finished frame gives one result beat with the held controller values.
// Throughput is one byte per clock unless in_stall holds the input: a byte sits in the
// input register, and the parser and staleness compare run in a single pass into the
// result register, which presents the result beat. in_stall rises only when a result
// is due while the result register is still stalled.
module controller_frame_deframer (
  input  logic                        clk,
  input  logic                        rst_n,
  // byte input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_end_of_datagram,
  // frame result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_frame_accepted,
  output logic [cfd_pkg::SEQ_W-1:0]   out_frame_sequence,
  output logic [cfd_pkg::STK_W-1:0]   out_stick_x,
  output logic [cfd_pkg::STK_W-1:0]   out_stick_y,
  output logic [cfd_pkg::BTN_W-1:0]   out_button_bits
);

  // input register
  logic       in_vld_r;
  logic [7:0] byte_r;
  logic       eod_r;

  cfd_pkg::frame_t frame;
  logic            out_busy;
  logic            step;
  logic            take;

  // the held byte moves on unless it finishes a frame and the result slot is stuck
  assign step     = in_vld_r && !(frame.done && out_busy);
  assign in_stall = in_vld_r && !step;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (take) begin
      in_vld_r <= 1'b1;
    end else if (step) begin
      in_vld_r <= 1'b0;
    end
  end

  // payload held while stalled
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_data_byte;
      eod_r  <= in_end_of_datagram;
    end
  end

  // marker hunt and body assembly
  cfd_parse u_parse (
    .clk             (clk),
    .rst_n           (rst_n),
    .byte_vld        (in_vld_r),
    .step            (step),
    .data_byte       (byte_r),
    .end_of_datagram (eod_r),
    .frame           (frame)
  );

  // staleness check, held values and result register
  cfd_hold u_hold (
    .clk                (clk),
    .rst_n              (rst_n),
    .step               (step),
    .frame              (frame),
    .busy               (out_busy),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_accepted (out_frame_accepted),
    .out_frame_sequence (out_frame_sequence),
    .out_stick_x        (out_stick_x),
    .out_stick_y        (out_stick_y),
    .out_button_bits    (out_button_bits)
  );

endmodule
